// ===== rtl/core/tros_pkg.sv =====
`default_nettype none

package tros_pkg;

    // Channel storage limits
    localparam int MAX_CHANNELS         = 8;
    localparam int NUM_CHANNELS_DEFAULT = 8;
    localparam int ID_W                 = 8;
    localparam int DELAY_W              = 16;
    localparam int SECS_W               = DELAY_W + 1;
    localparam int TICK_W               = 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_IDS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 2'd2;

    localparam logic [TICK_W-1:0] TPS_RESET = 8'd10;

    // Request kinds
    localparam logic REQ_CMD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Action codes
    localparam logic [2:0] ACT_OFF       = 3'd0;
    localparam logic [2:0] ACT_ON        = 3'd1;
    localparam logic [2:0] ACT_TOGGLE    = 3'd2;
    localparam logic [2:0] ACT_TIMED_OFF = 3'd3;
    localparam logic [2:0] ACT_TIMED_ON  = 3'd4;
    localparam logic [2:0] ACT_WAIT      = 3'd5;

    // Steady level codes; bit 1 set means unknown
    localparam logic [1:0] LVL_OFF     = 2'd0;
    localparam logic [1:0] LVL_ON      = 2'd1;
    localparam logic [1:0] LVL_UNKNOWN = 2'd2;

    // Per-channel view of one request
    typedef struct packed {
        logic               arm;
        logic               serve;
        logic               tick;
        logic [2:0]         action;
        logic [DELAY_W-1:0] delay;
    } t_chan_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/tros_channel.sv =====
`default_nettype none

module tros_channel
    import tros_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire t_chan_cmd         i_cmd,
    input  wire logic [TICK_W-1:0] i_tps,
    output logic                   o_drive,
    output logic                   o_pending
);

    logic [2:0]        r_act,    n_act;
    logic [SECS_W-1:0] r_secs,   n_secs;
    logic              r_pend,   n_pend;
    logic [1:0]        r_steady, n_steady;
    logic [TICK_W-1:0] r_ticks,  n_ticks;
    logic              r_drive,  n_drive;

    logic [2:0]        act;
    logic [SECS_W-1:0] secs;
    logic              pend;
    logic [SECS_W-1:0] secs_dec;
    logic [TICK_W-1:0] ticks_base;

    // An armed command takes effect before the channel is served
    always_comb begin
        act  = i_cmd.arm ? i_cmd.action : r_act;
        secs = i_cmd.arm ? ({1'b0, i_cmd.delay} + SECS_W'(1)) : r_secs;
        pend = i_cmd.arm | r_pend;
        secs_dec   = secs - SECS_W'(1);
        ticks_base = r_ticks;

        n_act    = act;
        n_secs   = secs;
        n_pend   = pend;
        n_steady = r_steady;
        n_ticks  = r_ticks;
        n_drive  = r_drive;

        if (i_cmd.serve && pend) begin
            unique case (act)
                ACT_OFF, ACT_ON: begin
                    n_drive  = (act == ACT_ON);
                    n_steady = (act == ACT_ON) ? LVL_ON : LVL_OFF;
                    n_pend   = 1'b0;
                end
                ACT_TOGGLE: begin
                    if (r_steady == LVL_OFF) begin
                        n_drive  = 1'b1;
                        n_steady = LVL_ON;
                    end else if (r_steady == LVL_ON) begin
                        n_drive  = 1'b0;
                        n_steady = LVL_OFF;
                    end
                    n_pend = 1'b0;
                end
                ACT_TIMED_OFF, ACT_TIMED_ON, ACT_WAIT: begin
                    if (secs != '0 && i_cmd.tick) begin
                        if (r_ticks >= i_tps) begin
                            ticks_base = '0;
                            n_secs     = secs_dec;
                            if (act != ACT_WAIT) begin
                                n_drive = (act == ACT_TIMED_ON);
                            end
                            if (secs_dec == '0) begin
                                // restore the steady level, or the opposite of the
                                // timed level when it was never known
                                if (act != ACT_WAIT) begin
                                    n_drive = r_steady[1] ? (act == ACT_TIMED_OFF)
                                                          : r_steady[0];
                                end
                                n_pend = 1'b0;
                            end
                        end
                        n_ticks = ticks_base + TICK_W'(1);
                    end
                end
                default: begin
                    // unused codes stay pending with no effect
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= ACT_OFF;
            r_secs   <= '0;
            r_pend   <= 1'b0;
            r_steady <= LVL_UNKNOWN;
            r_ticks  <= '0;
            r_drive  <= 1'b0;
        end else if (i_en) begin
            r_act    <= n_act;
            r_secs   <= n_secs;
            r_pend   <= n_pend;
            r_steady <= n_steady;
            r_ticks  <= n_ticks;
            r_drive  <= n_drive;
        end
    end

    assign o_drive   = r_drive;
    assign o_pending = r_pend;

endmodule

`default_nettype wire

// ===== rtl/core/timed_relay_output_sequencer.sv =====
`default_nettype none

// Relay output sequencer for up to NUM_CHANNELS relays. Each request on the
// slave stream is either a command (tuser low) that sets the action of one
// channel, picked by its configured ID, or of every channel in use when the
// ID is 0, or a time tick (tuser high) that advances all timed channels at
// once. Every request yields exactly one result: the relay drive levels and
// the mask of channels with an action still pending, as they stand after
// that request. The block takes one request per cycle unless the result
// stalls, and delivers its result at the edge that moves the request out of
// the input register; a stalled result holds the input register and so the
// slave stream. The rate is set by the single-stage next-state logic of the
// per-channel units, which all work in parallel. Configuration writes are
// taken at any time but must only be issued while no request is in flight.
// There is no clearing pass after reset.
module timed_relay_output_sequencer
    import tros_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [7:0] channel_id, [10:8] action, [26:11] delay_seconds, [31:27] zero
    input  wire logic [31:0]          s_axis_tdata,
    // [0] req_type
    input  wire logic                 s_axis_tuser,
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [7:0] pin_levels, [15:8] busy_mask
    output logic [15:0]               m_axis_tdata,
    // configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]          i_cfg_data
);

    // Configuration registers
    logic [3:0]        r_chan_count;
    logic [63:0]       r_chan_ids;
    logic [TICK_W-1:0] r_tps;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_count <= '0;
            r_chan_ids   <= '0;
            r_tps        <= TPS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CHANNEL_COUNT:    r_chan_count <= i_cfg_data[3:0];
                CFG_CHANNEL_IDS:      r_chan_ids   <= i_cfg_data;
                CFG_TICKS_PER_SECOND: r_tps        <= i_cfg_data[TICK_W-1:0];
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    // Input register: hold one request until the channel state can advance
    logic               r_in_valid;
    logic               r_in_type;
    logic [ID_W-1:0]    r_in_id;
    logic [2:0]         r_in_act;
    logic [DELAY_W-1:0] r_in_delay;
    logic               r_out_valid;
    logic               w_adv;

    // Advance when a request is held and the result slot is free or being taken
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_type  <= s_axis_tuser;
            r_in_id    <= s_axis_tdata[7:0];
            r_in_act   <= s_axis_tdata[10:8];
            r_in_delay <= s_axis_tdata[26:11];
        end
    end

    // Result valid: the channel state registers themselves hold the result,
    // since they only move when the previous result has been taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Channel addressing: ID 0 arms every channel in use, otherwise only the
    // lowest channel in use whose ID matches
    logic                  w_is_cmd;
    logic                  w_tick;
    logic                  w_broadcast;
    logic [NUM_CHANNELS:0] w_found;
    logic [7:0]            w_pins;
    logic [7:0]            w_busy;

    assign w_is_cmd    = (r_in_type == REQ_CMD);
    assign w_tick      = (r_in_type == REQ_TICK);
    assign w_broadcast = (r_in_id == '0);
    assign w_found[0]  = 1'b0;

    for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
        localparam logic [3:0] CH_IDX = 4'(i);

        logic      w_in_use;
        logic      w_match;
        t_chan_cmd w_cmd;

        assign w_in_use       = (r_chan_count > CH_IDX);
        assign w_match        = w_in_use && (r_chan_ids[ID_W*i +: ID_W] == r_in_id);
        assign w_found[i + 1] = w_found[i] | w_match;

        assign w_cmd.arm    = w_is_cmd && w_in_use && (w_broadcast || (w_match && !w_found[i]));
        assign w_cmd.serve  = w_in_use;
        assign w_cmd.tick   = w_tick;
        assign w_cmd.action = r_in_act;
        assign w_cmd.delay  = r_in_delay;

        tros_channel u_channel (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_adv),
            .i_cmd     (w_cmd),
            .i_tps     (r_tps),
            .o_drive   (w_pins[i]),
            .o_pending (w_busy[i])
        );
    end

    // Channels beyond the configured build size read as idle and off
    for (genvar b = NUM_CHANNELS; b < MAX_CHANNELS; b++) begin : g_unused
        assign w_pins[b] = 1'b0;
        assign w_busy[b] = 1'b0;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {w_busy, w_pins};

    // A full input register behind a stalled result must refuse new requests
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("request accepted while the pipeline was stalled");

    // Every advance leaves a result waiting
    a_adv_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> m_axis_tvalid)
        else $error("advance without a result");

    // With no channel in use a request changes nothing
    a_no_channels_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_chan_count == '0) |=> ($stable(w_pins) && $stable(w_busy)))
        else $error("channel state moved with no channel in use");

    // A tick never starts a new action
    a_tick_never_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_tick) |=> ((w_busy & ~$past(w_busy)) == '0))
        else $error("pending bit raised by a tick");

endmodule

`default_nettype wire
